@@ rtl/core/anp_pkg.sv @@
// anp_pkg: shared constants, item types and the digit decoder for the ascii number parser
// no dependencies; used by the character and value channel interfaces and every rtl/core module
package anp_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned DigitWidth = 4;

  localparam logic [CharWidth-1:0] ChSpace      = 8'h20;
  localparam logic [CharWidth-1:0] ChUnderscore = 8'h5f;
  localparam logic [CharWidth-1:0] ChMinus      = 8'h2d;
  localparam logic [CharWidth-1:0] ChZero       = 8'h30;
  localparam logic [CharWidth-1:0] ChNine       = 8'h39;
  localparam logic [CharWidth-1:0] ChUpA        = 8'h41;
  localparam logic [CharWidth-1:0] ChUpF        = 8'h46;
  localparam logic [CharWidth-1:0] ChLoA        = 8'h61;
  localparam logic [CharWidth-1:0] ChLoF        = 8'h66;

  localparam logic [DigitWidth-1:0] DigitTen = 4'd10;

  // one character of a field as held in the input register
  typedef struct packed {
    logic [CharWidth-1:0] char_code;
    logic                 last;
  } item_t;

  // input register to parse stage handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic                  is_digit;
    logic [DigitWidth-1:0] digit;
  } digit_t;

  // digit value of a character in the selected radix
  function automatic digit_t decode_digit(logic [CharWidth-1:0] c, logic hex_mode);
    digit_t                r;
    logic [CharWidth-1:0]  off;
    r   = '0;
    off = '0;
    if (c >= ChZero && c <= ChNine) begin
      off        = c - ChZero;
      r.is_digit = 1'b1;
      r.digit    = off[DigitWidth-1:0];
    end else if (hex_mode && c >= ChUpA && c <= ChUpF) begin
      off        = c - ChUpA;
      r.is_digit = 1'b1;
      r.digit    = off[DigitWidth-1:0] + DigitTen;
    end else if (hex_mode && c >= ChLoA && c <= ChLoF) begin
      off        = c - ChLoA;
      r.is_digit = 1'b1;
      r.digit    = off[DigitWidth-1:0] + DigitTen;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/anp_char_if.sv @@
// anp_char_if: character channel, one ascii character and its last flag per item
// depends on anp_pkg for widths
interface anp_char_if;
  logic                          valid;
  logic                          ready;
  logic [anp_pkg::CharWidth-1:0] char_code;
  logic                          last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/core/anp_value_if.sv @@
// anp_value_if: result channel, one parsed 32-bit value per item
// depends on anp_pkg for widths
interface anp_value_if;
  logic                           valid;
  logic                           ready;
  logic [anp_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/core/anp_cfg_if.sv @@
// anp_cfg_if: configuration write channel carrying the radix select register
// no package dependencies
interface anp_cfg_if;
  logic valid;
  logic ready;
  logic hex_mode;

  modport source (output valid, output hex_mode, input ready);
  modport sink   (input valid, input hex_mode, output ready);
endinterface

@@ rtl/core/ascii_number_parser_core.sv @@
// ascii_number_parser_core: ascii decimal or hex field to signed 32-bit value
// path: a last character passes the input register and then the result register before its value shows on out_ch
// throughput: one character per cycle unless a last character stalls as below; the result register parts the two sides
// stalls: a last character waits in the input register while out_ch holds an unaccepted value
// reset (rst, synchronous): pipeline empty, field state cleared, hex_mode = 1
// depends on anp_pkg, anp_char_if, anp_value_if, anp_cfg_if, anp_in_reg, anp_parse
module ascii_number_parser_core (
  input  logic         clk,
  input  logic         rst,
  anp_char_if.sink     in_ch,
  anp_value_if.source  out_ch,
  anp_cfg_if.sink      cfg
);

  // radix select; the user must write it only while the block is idle, the block does not enforce this
  logic             hex_mode;
  anp_pkg::stage_t  stage;
  logic             take;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hex_mode <= 1'b1;
    end else if (cfg.valid) begin
      hex_mode <= cfg.hex_mode;
    end
  end

  // input register: one character item held for the parse stage
  anp_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  // parse stage: blank/sign/digit handling, shift-add, result register
  anp_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .hex_mode (hex_mode),
    .stage    (stage),
    .take     (take),
    .out_ch   (out_ch)
  );

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result pending after reset");

  // a consumed last character always produces a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    (take && stage.item.last) |=> out_ch.valid)
    else $error("last character consumed without a result");

  // a held character that was not consumed is still held
  assert property (@(posedge clk) disable iff (rst)
    (stage.valid && !take) |=> stage.valid)
    else $error("stalled character lost");

  // a configuration write lands in the radix register
  assert property (@(posedge clk) disable iff (rst)
    (cfg.valid && cfg.ready) |=> (hex_mode == $past(cfg.hex_mode)))
    else $error("radix register write lost");

endmodule

@@ rtl/core/anp_in_reg.sv @@
// anp_in_reg: input register stage, captures one character item per cycle
// unless the held item is not taken; depends on anp_pkg and anp_char_if
module anp_in_reg (
  input  logic              clk,
  input  logic              rst,
  anp_char_if.sink          in_ch,
  input  logic              take,
  output anp_pkg::stage_t   stage
);

  logic            valid;
  anp_pkg::item_t  item;

  // free when empty or when the parse stage consumes the held item
  assign in_ch.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.ready) begin
      valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.char_code <= in_ch.char_code;
      item.last      <= in_ch.last;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

@@ rtl/core/anp_parse.sv @@
// anp_parse: field state, shift-add accumulation and the result register
// depends on anp_pkg and anp_value_if
module anp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hex_mode,
  input  anp_pkg::stage_t      stage,
  output logic                 take,
  anp_value_if.source          out_ch
);

  logic [anp_pkg::ValueWidth-1:0] accumulator;
  logic [anp_pkg::ValueWidth-1:0] accumulator_next;
  logic                           negative;
  logic                           negative_next;
  logic                           leading_phase;
  logic                           leading_phase_next;
  logic                           stopped;
  logic                           stopped_next;
  logic                           out_valid;
  logic [anp_pkg::ValueWidth-1:0] value;
  logic [anp_pkg::ValueWidth-1:0] scaled;
  logic [anp_pkg::ValueWidth-1:0] result;
  logic [anp_pkg::CharWidth-1:0]  c;
  anp_pkg::digit_t                dig;
  logic                           emit;

  // a non-last item never needs the result slot
  assign take = stage.valid && (!stage.item.last || !out_valid || out_ch.ready);
  assign emit = take && stage.item.last;
  assign c    = stage.item.char_code;
  assign dig  = anp_pkg::decode_digit(c, hex_mode);

  // times 16 as a shift, or times 10 as shifts and one add
  assign scaled = hex_mode ? (accumulator << 4) : ((accumulator << 3) + (accumulator << 1));

  always_comb begin
    accumulator_next   = accumulator;
    negative_next      = negative;
    leading_phase_next = leading_phase;
    stopped_next       = stopped;
    if (!stopped) begin
      if (c == anp_pkg::ChSpace || c == anp_pkg::ChUnderscore) begin
        if (!leading_phase) begin
          stopped_next = 1'b1;
        end
      end else if (c == anp_pkg::ChMinus) begin
        if (leading_phase) begin
          negative_next      = 1'b1;
          leading_phase_next = 1'b0;
        end else begin
          stopped_next = 1'b1;
        end
      end else if (dig.is_digit) begin
        accumulator_next   = scaled + {{(anp_pkg::ValueWidth-anp_pkg::DigitWidth){1'b0}}, dig.digit};
        leading_phase_next = 1'b0;
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  assign result = negative_next ? (~accumulator_next + 1'b1) : accumulator_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator   <= '0;
      negative      <= 1'b0;
      leading_phase <= 1'b1;
      stopped       <= 1'b0;
    end else if (emit) begin
      accumulator   <= '0;
      negative      <= 1'b0;
      leading_phase <= 1'b1;
      stopped       <= 1'b0;
    end else if (take) begin
      accumulator   <= accumulator_next;
      negative      <= negative_next;
      leading_phase <= leading_phase_next;
      stopped       <= stopped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value <= result;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.value = value;

endmodule

@@ test/anp_value_checker.sv @@
// anp_value_checker: watches the character, value and radix channels of the parser
// and scores every parsed value against its own prediction; depends on anp_pkg and the channel interfaces
module anp_value_checker (
  input  logic      clk,
  input  logic      rst,
  anp_char_if       chars,
  anp_value_if      values,
  anp_cfg_if        cfg,
  output int        mismatches,
  output int        pending,
  output int        values_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import anp_pkg::*;

  logic [ValueWidth-1:0] expected_values[$];

  // field state as the parser should hold it
  logic [ValueWidth-1:0] magnitude;
  logic                  minus_seen;
  logic                  awaiting_number;
  logic                  halted;
  logic                  radix_hex;

  function automatic void clear_field();
    magnitude       = '0;
    minus_seen      = 1'b0;
    awaiting_number = 1'b1;
    halted          = 1'b0;
  endfunction

  // fold one character into the field state
  function automatic void absorb_char(input logic [CharWidth-1:0] c);
    logic [DigitWidth-1:0] d;
    logic                  is_digit;
    is_digit = 1'b0;
    d        = '0;
    if (c >= ChZero && c <= ChNine) begin
      is_digit = 1'b1;
      d        = DigitWidth'(c - ChZero);
    end else if (radix_hex && c >= ChUpA && c <= ChUpF) begin
      is_digit = 1'b1;
      d        = DigitWidth'(c - ChUpA + 8'd10);
    end else if (radix_hex && c >= ChLoA && c <= ChLoF) begin
      is_digit = 1'b1;
      d        = DigitWidth'(c - ChLoA + 8'd10);
    end
    if (halted) return;
    if (c == ChSpace || c == ChUnderscore) begin
      if (!awaiting_number) halted = 1'b1;
    end else if (c == ChMinus) begin
      if (awaiting_number) begin
        minus_seen      = 1'b1;
        awaiting_number = 1'b0;
      end else begin
        halted = 1'b1;
      end
    end else if (is_digit) begin
      magnitude       = magnitude * (radix_hex ? 32'd16 : 32'd10) + ValueWidth'(d);
      awaiting_number = 1'b0;
    end else begin
      halted = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    logic [ValueWidth-1:0] want;
    if (rst) begin
      clear_field();
      radix_hex = 1'b1;
      expected_values.delete();
    end else begin
      // score outgoing values before queuing new ones from this edge
      if (values.valid && values.ready) begin
        values_checked++;
        if (expected_values.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected value %08h with nothing pending", values.value);
          mismatches++;
        end else begin
          want = expected_values.pop_front();
          if (values.value !== want) begin
            if (mismatches < 10)
              $display("value mismatch: expected %08h, got %08h", want, values.value);
            mismatches++;
          end
        end
      end
      if (cfg.valid && cfg.ready) radix_hex = cfg.hex_mode;
      if (chars.valid && chars.ready) begin
        absorb_char(chars.char_code);
        if (chars.last) begin
          expected_values.push_back(minus_seen ? (32'd0 - magnitude) : magnitude);
          clear_field();
        end
      end
    end
    pending = expected_values.size();
  end

endmodule

@@ test/tb.sv @@
// tb: top of the ascii number parser regression; drives characters and radix writes
// depends on anp_pkg, the channel interfaces, ascii_number_parser_core and anp_value_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import anp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  anp_char_if  in_ch();
  anp_value_if out_ch();
  anp_cfg_if   cfg();

  int chk_mismatches;
  int chk_pending;
  int chk_values;

  // stimulus bookkeeping
  int   chars_sent;
  int   fields_sent;
  int   radix_writes;
  int   burst_left;
  logic stim_hex;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ascii_number_parser_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  anp_value_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .chars          (in_ch),
    .values         (out_ch),
    .cfg            (cfg),
    .mismatches     (chk_mismatches),
    .pending        (chk_pending),
    .values_checked (chk_values)
  );

  // watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side: randomly chosen calm phases and phases with random stalls of varying length
  initial begin
    int  stall_left;
    int  phase_left;
    bit  calm;
    stall_left     = 0;
    phase_left     = 0;
    calm           = 1'b0;
    out_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        phase_left = $urandom_range(20, 120);
        calm       = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // present one character at a falling edge and hold it until accepted;
  // called and returning at a falling edge
  task automatic send_char(input logic [CharWidth-1:0] c, input logic is_last);
    int idle;
    if (burst_left == 0) begin
      // new burst; a quarter of them follow on without any gap
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        in_ch.valid <= 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.char_code <= c;
    in_ch.last      <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    chars_sent++;
    if (is_last) fields_sent++;
  endtask

  // directed text; the final character carries the last flag when asked
  task automatic send_text(input string s, input bit mark_last);
    for (int i = 0; i < s.len(); i++)
      send_char(CharWidth'(s[i]), mark_last && (i == s.len() - 1));
  endtask

  // let the parser drain, then change the radix while nothing is in flight
  task automatic write_radix(input logic hex);
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    // a character without the last flag leaves no value behind,
    // so allow the input register and result register plus margin to settle
    repeat (4) @(negedge clk);
    cfg.valid    <= 1'b1;
    cfg.hex_mode <= hex;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
    stim_hex = hex;
    radix_writes++;
  endtask

  // a digit that is legal in the current radix, letters in both cases for hex
  function automatic logic [CharWidth-1:0] random_digit();
    int v;
    v = stim_hex ? $urandom_range(0, 15) : $urandom_range(0, 9);
    if (v < 10) return ChZero + CharWidth'(v);
    return ($urandom_range(0, 1) ? ChUpA : ChLoA) + CharWidth'(v - 10);
  endfunction

  // one random field: mostly well formed numbers, some broken ones, some pure noise
  task automatic random_field();
    logic [CharWidth-1:0] field[$];
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      // raw bytes over the whole code range
      n = $urandom_range(1, 6);
      repeat (n) field.push_back(CharWidth'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) field.push_back($urandom_range(0, 1) ? ChSpace : ChUnderscore);
      if ($urandom_range(0, 2) == 0) field.push_back(ChMinus);
      // long digit runs can wrap the 32-bit accumulator
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
      repeat (n) field.push_back(random_digit());
      if (kind == 7) begin
        // break the number: blank, minus, or any byte, then up to three more digits
        case ($urandom_range(0, 2))
          0: field.push_back($urandom_range(0, 1) ? ChSpace : ChUnderscore);
          1: field.push_back(ChMinus);
          default: field.push_back(CharWidth'($urandom_range(0, 255)));
        endcase
        repeat ($urandom_range(0, 3)) field.push_back(random_digit());
      end
    end
    foreach (field[i]) send_char(field[i], i == field.size() - 1);
  endtask

  initial begin
    int since_write;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last      = 1'b0;
    cfg.valid       = 1'b0;
    cfg.hex_mode    = 1'b1;
    chars_sent      = 0;
    fields_sent     = 0;
    radix_writes    = 0;
    burst_left      = 0;
    stim_hex        = 1'b1;   // parser comes out of reset in hex mode
    since_write     = 0;
    rst             = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, hex mode from reset
    send_text("_ -fF", 1'b1);           // leading blanks, minus, both letter cases
    send_char(8'hff, 1'b1);             // top code alone stops at once, gives zero
    send_char(8'h00, 1'b0);             // bottom code stops the field ...
    send_text("1", 1'b1);               // ... so the digit after it is ignored
    send_text("-1-", 1'b1);             // second minus stops accumulation
    send_text("-", 1'b1);               // minus with no digits
    send_text("1 2", 1'b1);             // blank after the number ends it

    write_radix(1'b0);
    send_text("5a7", 1'b1);             // letter is no digit in decimal
    send_text("12", 1'b0);              // field left open across a radix change
    write_radix(1'b1);
    send_text("f", 1'b1);               // rest of the field in hex

    // random part, with a radix change now and then between fields
    while (chars_sent < 1620) begin
      if (since_write > 150) begin
        write_radix($urandom_range(0, 1));
        since_write = 0;
      end
      n_chars_before: begin
        int start_count;
        start_count = chars_sent;
        random_field();
        since_write += chars_sent - start_count;
      end
    end

    // drain and let the pipeline settle
    in_ch.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d characters in %0d fields with %0d radix writes",
             chars_sent, fields_sent, radix_writes);
    $display("checked %0d values, %0d mismatches, %0d still pending",
             chk_values, chk_mismatches, chk_pending);
    if (chk_mismatches == 0 && chk_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
